/* rtl/core/jmqt_pkg.sv */
package jmqt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths
  localparam int JOB_W   = 32;
  localparam int LIM_W   = 44;
  localparam int BYTES_W = 64;
  localparam int TOT_W   = 48;
  localparam int PCT_W   = 16;
  localparam int MB_W    = BYTES_W - 20;
  localparam int PROD_W  = LIM_W + PCT_W;
  localparam int REM_W   = 7;
  localparam int PCT_DIV = 100;

  // Stream widths
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 128;

  // Request kinds
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_USAGE    = 2'd1;
  localparam logic [1:0] REQ_SWEEP    = 2'd2;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  // Event codes
  localparam logic [2:0] EV_ACCEPT = 3'd0;
  localparam logic [2:0] EV_IGNORE = 3'd1;
  localparam logic [2:0] EV_FULL   = 3'd2;
  localparam logic [2:0] EV_REAL   = 3'd3;
  localparam logic [2:0] EV_VIRT   = 3'd4;
  localparam logic [2:0] EV_PURGE  = 3'd5;
  localparam logic [2:0] EV_DONE   = 3'd6;

  // Config register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_PCT    = 1'b1;

  // One entry of the limit/usage memory
  typedef struct packed {
    logic [LIM_W-1:0] limit;
    logic [TOT_W-1:0] real_tot;
    logic [TOT_W-1:0] virt_tot;
  } ram_word_t;

  localparam int RAM_W = $bits(ram_word_t);

endpackage

/* rtl/core/jmqt_ram.sv */
module jmqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/jmqt_div100.sv */
module jmqt_div100 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [jmqt_pkg::PROD_W-1:0] dividend,
  output logic                       done,
  output logic [jmqt_pkg::PROD_W-1:0] quotient
);

  // Quotient = (dividend * ceil(2^SH / 100)) >> SH, exact for every dividend width PROD_W
  localparam int L2D   = $clog2(jmqt_pkg::PCT_DIV);
  localparam int SH    = jmqt_pkg::PROD_W + L2D;
  localparam int XL_W  = jmqt_pkg::PROD_W / 2;
  localparam int XH_W  = jmqt_pkg::PROD_W - XL_W;
  localparam int ML_W  = 31;
  localparam int MH_W  = 30;
  localparam int ACC_W = jmqt_pkg::PROD_W + ML_W + MH_W;
  localparam logic [ML_W+MH_W-1:0] RECIP =
    (ML_W+MH_W)'(((128'd1 << SH) / 128'(jmqt_pkg::PCT_DIV)) + 128'd1);
  localparam logic [ML_W-1:0] M_LO = RECIP[ML_W-1:0];
  localparam logic [MH_W-1:0] M_HI = RECIP[ML_W+MH_W-1:ML_W];

  logic [jmqt_pkg::PROD_W-1:0] dvd_r;
  logic [ACC_W-1:0]            acc_r, term;
  logic [XH_W-1:0]             op_a;
  logic [ML_W-1:0]             op_b;
  logic [XH_W+ML_W-1:0]        prod;
  logic [1:0]                  cnt_r;
  logic                        busy_r, done_r;

  // One partial product per cycle: dividend half times reciprocal half
  always_comb begin
    op_a = cnt_r[1] ? dvd_r[jmqt_pkg::PROD_W-1:XL_W] : dvd_r[XL_W-1:0];
    op_b = cnt_r[0] ? ML_W'(M_HI) : M_LO;
    prod = op_a * op_b;
    case (cnt_r)
      2'd0:    term = ACC_W'(prod);
      2'd1:    term = ACC_W'(prod) << ML_W;
      2'd2:    term = ACC_W'(prod) << XL_W;
      default: term = ACC_W'(prod) << (XL_W + ML_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + term;
    end
  end

  assign done     = done_r;
  assign quotient = jmqt_pkg::PROD_W'(acc_r[ACC_W-1:SH]);

endmodule

/* rtl/core/job_memory_quota_table_top.sv */
// Register and usage requests: read, checked and written back in S_LOOK, then sent in S_EMIT;
// ignored ones go straight to S_EMIT. Requests are taken only in S_IDLE. Sweep: S_SW_NEXT
// skips empty slots, S_SW_EVAL checks each valid entry, S_SW_MUL and S_SW_DIV add a
// virtual check (reciprocal multiply, one partial product a cycle), S_EMIT sends each result
// and the done result; output stalls hold S_EMIT. rst_n (synchronous, active low) clears
// entries, totals, config and the output; totals carry a per-entry valid flag in flops, so there is no clearing pass.
module job_memory_quota_table_top (
  input  logic         clk,
  input  logic         rst_n,
  // config
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // job_id[31:0], limit_mb[75:32], rss_bytes[139:76], vsize_bytes[203:140], zero pad
  input  logic [jmqt_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_job_id[31:0], used_mb[79:32], limit_out_mb[127:80]
  output logic [jmqt_pkg::OUT_DATA_W-1:0] out_tdata,
  // event_code[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam int D  = jmqt_pkg::TABLE_DEPTH;
  localparam int IW = jmqt_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_SW_NEXT, S_SW_EVAL, S_SW_MUL, S_SW_DIV, S_EMIT
  } state_t;

  state_t state_r, ret_r;

  // config
  logic                        enable_r;
  logic [jmqt_pkg::PCT_W-1:0]  pct_r;

  // entry tags in flops for parallel match
  logic [D-1:0]                valid_r, tot_ok_r;
  logic [jmqt_pkg::JOB_W-1:0]  job_q_r [D];

  // latched request
  logic [1:0]                  req_r;
  logic [jmqt_pkg::JOB_W-1:0]  job_r;
  logic [jmqt_pkg::LIM_W-1:0]  lim_in_r;
  logic [jmqt_pkg::BYTES_W-1:0] rss_r, vsz_r;
  logic                        hit_r, free_ok_r;
  logic [IW-1:0]               idx_r;

  // sweep
  logic [IW:0]                 sw_idx_r;
  logic [jmqt_pkg::TOT_W-1:0]  virt_r;
  logic [jmqt_pkg::PROD_W-1:0] prod_r;

  // pending result
  logic [jmqt_pkg::JOB_W-1:0]  res_job_r;
  logic [2:0]                  res_code_r;
  logic [jmqt_pkg::TOT_W-1:0]  res_used_r, res_lim_r;
  logic                        res_last_r;

  // output register
  logic                        out_valid_r;
  logic [jmqt_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [2:0]                  out_user_r;
  logic                        out_last_r;

  // memory
  logic                        ram_we;
  logic [IW-1:0]               ram_raddr;
  jmqt_pkg::ram_word_t         ram_wdata, ram_rdata;

  // divider
  logic                        div_start, div_done;
  logic [jmqt_pkg::PROD_W-1:0] div_quo;

  // input fields
  logic [jmqt_pkg::JOB_W-1:0]  in_job;
  logic                        in_fire;
  assign in_job  = in_tdata[31:0];
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Parallel match and first free slot
  logic          hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
    for (int i = 0; i < D; i++) begin
      if (!hit && valid_r[i] && job_q_r[i] == in_job) begin
        hit = 1'b1; hit_idx = IW'(i);
      end
      if (!free_ok && !valid_r[i]) begin
        free_ok = 1'b1; free_idx = IW'(i);
      end
    end
  end

  // Read address
  always_comb begin
    if (state_r == S_IDLE) begin
      ram_raddr = hit ? hit_idx : free_idx;
    end else begin
      ram_raddr = sw_idx_r[IW-1:0];
    end
  end

  // Entry as read, totals masked by their valid flag
  logic [jmqt_pkg::TOT_W-1:0] rd_real, rd_virt;
  logic [IW-1:0]              rd_idx;
  assign rd_idx  = (state_r == S_LOOK) ? idx_r : sw_idx_r[IW-1:0];
  assign rd_real = tot_ok_r[rd_idx] ? ram_rdata.real_tot : '0;
  assign rd_virt = tot_ok_r[rd_idx] ? ram_rdata.virt_tot : '0;

  // Usage conversion and saturating add
  function automatic logic [jmqt_pkg::TOT_W-1:0] add_usage(
    input logic [jmqt_pkg::TOT_W-1:0]   tot,
    input logic [jmqt_pkg::BYTES_W-1:0] bytes
  );
    logic [jmqt_pkg::MB_W-1:0]  mb;
    logic [jmqt_pkg::TOT_W:0]   s;
    mb = bytes[jmqt_pkg::BYTES_W-1:20];
    if (mb == '0) mb = jmqt_pkg::MB_W'(1);
    s = {1'b0, tot} + (jmqt_pkg::TOT_W+1)'(mb);
    if (&bytes) return tot;
    return s[jmqt_pkg::TOT_W] ? '1 : s[jmqt_pkg::TOT_W-1:0];
  endfunction

  // Write-back data for register and usage requests
  logic rd_over_real;
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (state_r == S_LOOK) begin
      if (req_r == jmqt_pkg::REQ_REGISTER) begin
        if (hit_r) begin
          ram_we = lim_in_r > ram_rdata.limit;
          ram_wdata.limit = lim_in_r;
        end else begin
          ram_we = free_ok_r;
          ram_wdata.limit    = lim_in_r;
          ram_wdata.real_tot = '0;
          ram_wdata.virt_tot = '0;
        end
      end else begin
        ram_we = hit_r;
        ram_wdata.real_tot = add_usage(rd_real, rss_r);
        ram_wdata.virt_tot = add_usage(rd_virt, vsz_r);
      end
    end
  end

  assign rd_over_real = (ram_rdata.limit != '0) &&
                        (rd_real > jmqt_pkg::TOT_W'(ram_rdata.limit));
  assign div_start    = (state_r == S_SW_MUL);

  jmqt_ram #(.WIDTH(jmqt_pkg::RAM_W), .DEPTH(D)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  jmqt_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Control, table tags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      enable_r    <= 1'b0;
      pct_r       <= '0;
      valid_r     <= '0;
      tot_ok_r    <= '0;
      sw_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          jmqt_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
          jmqt_pkg::CFG_PCT:    pct_r    <= cfg_wdata;
        endcase
      end
      // sink took the result and no new one replaces it
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r     <= in_tuser;
            job_r     <= in_job;
            lim_in_r  <= in_tdata[75:32];
            rss_r     <= in_tdata[139:76];
            vsz_r     <= in_tdata[203:140];
            hit_r     <= hit && (in_job != '0);
            free_ok_r <= free_ok;
            idx_r     <= hit ? hit_idx : free_idx;
            res_job_r  <= (in_tuser == jmqt_pkg::REQ_SWEEP) ? '0 : in_job;
            res_used_r <= '0;
            res_lim_r  <= '0;
            res_last_r <= 1'b1;
            res_code_r <= jmqt_pkg::EV_IGNORE;
            ret_r      <= S_IDLE;
            sw_idx_r   <= '0;
            if (!enable_r || in_tuser == jmqt_pkg::REQ_UNUSED) begin
              state_r <= S_EMIT;
            end else if (in_tuser == jmqt_pkg::REQ_SWEEP) begin
              state_r <= S_SW_NEXT;
            end else if (in_tuser == jmqt_pkg::REQ_REGISTER &&
                         (in_job == '0 || in_tdata[75:32] == '0)) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end

        S_LOOK: begin
          if (req_r == jmqt_pkg::REQ_REGISTER) begin
            if (hit_r) begin
              res_code_r <= jmqt_pkg::EV_ACCEPT;
            end else if (free_ok_r) begin
              valid_r[idx_r]  <= 1'b1;
              tot_ok_r[idx_r] <= 1'b0;
              job_q_r[idx_r]  <= job_r;
              res_code_r      <= jmqt_pkg::EV_ACCEPT;
            end else begin
              res_code_r <= jmqt_pkg::EV_FULL;
            end
          end else if (hit_r) begin
            tot_ok_r[idx_r] <= 1'b1;
            res_code_r      <= jmqt_pkg::EV_ACCEPT;
          end else begin
            res_code_r <= jmqt_pkg::EV_IGNORE;
          end
          state_r <= S_EMIT;
        end

        // Step to the next valid entry, or finish
        S_SW_NEXT: begin
          if (sw_idx_r == (IW+1)'(D)) begin
            tot_ok_r   <= '0;
            res_job_r  <= '0;
            res_code_r <= jmqt_pkg::EV_DONE;
            res_used_r <= '0;
            res_lim_r  <= '0;
            res_last_r <= 1'b1;
            ret_r      <= S_IDLE;
            state_r    <= S_EMIT;
          end else if (valid_r[sw_idx_r[IW-1:0]]) begin
            ret_r   <= S_SW_NEXT;
            state_r <= S_SW_EVAL;
          end else begin
            sw_idx_r <= sw_idx_r + 1'b1;
          end
        end

        S_SW_EVAL: begin
          res_job_r  <= job_q_r[sw_idx_r[IW-1:0]];
          res_last_r <= 1'b0;
          virt_r     <= rd_virt;
          prod_r     <= ram_rdata.limit * pct_r;
          if (rd_real == '0) begin
            valid_r[sw_idx_r[IW-1:0]] <= 1'b0;
            res_code_r <= jmqt_pkg::EV_PURGE;
            res_used_r <= '0;
            res_lim_r  <= '0;
            sw_idx_r   <= sw_idx_r + 1'b1;
            state_r    <= S_EMIT;
          end else if (rd_over_real) begin
            res_code_r <= jmqt_pkg::EV_REAL;
            res_used_r <= rd_real;
            res_lim_r  <= jmqt_pkg::TOT_W'(ram_rdata.limit);
            sw_idx_r   <= sw_idx_r + 1'b1;
            state_r    <= S_EMIT;
          end else if (pct_r != '0 && ram_rdata.limit != '0) begin
            state_r <= S_SW_MUL;
          end else begin
            sw_idx_r <= sw_idx_r + 1'b1;
            state_r  <= S_SW_NEXT;
          end
        end

        S_SW_MUL: begin
          state_r <= S_SW_DIV;
        end

        // Virtual limit ready: compare against the virtual total
        S_SW_DIV: begin
          if (div_done) begin
            sw_idx_r <= sw_idx_r + 1'b1;
            if (div_quo != '0 && jmqt_pkg::PROD_W'(virt_r) > div_quo) begin
              res_code_r <= jmqt_pkg::EV_VIRT;
              res_used_r <= virt_r;
              res_lim_r  <= div_quo[jmqt_pkg::TOT_W-1:0];
              state_r    <= S_EMIT;
            end else begin
              state_r <= S_SW_NEXT;
            end
          end
        end

        // Hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_lim_r, res_used_r, res_job_r};
            out_user_r  <= res_code_r;
            out_last_r  <= res_last_r;
            state_r     <= ret_r;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
